@@ rtl/core/mfd_pkg.sv @@
// Shared types and constants of the message frame deframer.
`default_nettype none
package mfd_pkg;

	localparam int unsigned BODY_LEN_W = 15;
	localparam int unsigned DIGIT_W = 7;
	localparam logic [BODY_LEN_W-1:0] MIN_BODY_LEN = 15'd9;

	typedef enum logic [3:0] {
		PH_VER0  = 4'd0,
		PH_VER1  = 4'd1,
		PH_LENHI = 4'd2,
		PH_LENLO = 4'd3,
		PH_TAG   = 4'd4,
		PH_FHI   = 4'd5,
		PH_FLO   = 4'd6,
		PH_DATA  = 4'd7,
		PH_SKIP  = 4'd8
	} phase_t;

	localparam logic [1:0] TAG_MAX = 2'd2;
	localparam logic [1:0] FIELD_COUNT = 2'd3;

	typedef struct packed {
		logic       data_valid;
		logic [1:0] field_tag;
		logic [7:0] data_byte;
		logic       field_last;
		logic       frame_done;
		logic       frame_error;
	} result_t;

	// two base-127 digits to a value: 127*hi + lo
	function automatic logic [BODY_LEN_W-1:0] base127(input logic [DIGIT_W-1:0] hi,
		input logic [DIGIT_W-1:0] lo);
		base127 = {1'b0, hi, 7'd0} - {8'd0, hi} + {8'd0, lo};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/mfd_front.sv @@
// Byte parser: walks the frame format and classifies each byte into a result.
`default_nettype none
module mfd_front import mfd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	output logic               push,
	output result_t            push_res
);

	phase_t                phase_q, phase_d;
	logic                  hdr_ok_q, hdr_ok_d;
	logic [DIGIT_W-1:0]    high_q, high_d;
	logic [BODY_LEN_W-1:0] body_q, body_d;
	logic [1:0]            fidx_q, fidx_d;
	logic [1:0]            tag_q, tag_d;
	logic [BODY_LEN_W-1:0] frem_q, frem_d;
	logic                  err_q, err_d;

	logic [BODY_LEN_W-1:0] body_dec, frem_dec, len_v, need_v, tail_v;
	logic [1:0]            fidx_inc;
	logic                  has_res, err_hit, close_f;
	result_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_VER0;
			hdr_ok_q <= 1'b1;
			high_q   <= '0;
			body_q   <= '0;
			fidx_q   <= '0;
			tag_q    <= '0;
			frem_q   <= '0;
			err_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			hdr_ok_q <= hdr_ok_d;
			high_q   <= high_d;
			body_q   <= body_d;
			fidx_q   <= fidx_d;
			tag_q    <= tag_d;
			frem_q   <= frem_d;
			err_q    <= err_d;
		end
	end

	assign body_dec = (body_q != '0) ? body_q - 1'b1 : '0;
	assign frem_dec = (frem_q != '0) ? frem_q - 1'b1 : '0;
	assign fidx_inc = fidx_q + 2'd1;
	assign tail_v   = (fidx_q == 2'd0) ? 15'd6 : ((fidx_q == 2'd1) ? 15'd3 : 15'd0);

	always_comb begin
		phase_d  = phase_q;
		hdr_ok_d = hdr_ok_q;
		high_d   = high_q;
		body_d   = body_q;
		fidx_d   = fidx_q;
		tag_d    = tag_q;
		frem_d   = frem_q;
		err_d    = err_q;
		res      = '0;
		has_res  = 1'b0;
		err_hit  = 1'b0;
		close_f  = 1'b0;
		len_v    = '0;
		need_v   = '0;
		if (!err_q) begin
			unique case (phase_q)
				PH_VER0: begin
					if (in_byte != 8'd1) hdr_ok_d = 1'b0;
					phase_d = PH_VER1;
				end
				PH_VER1: begin
					if (in_byte != 8'd0) hdr_ok_d = 1'b0;
					phase_d = PH_LENHI;
				end
				PH_LENHI: begin
					if (in_byte[7]) hdr_ok_d = 1'b0;
					high_d  = in_byte[6:0];
					phase_d = PH_LENLO;
				end
				PH_LENLO: begin
					len_v = base127(high_q, in_byte[6:0]);
					if (!hdr_ok_q || in_byte[7] || len_v < MIN_BODY_LEN) begin
						err_hit = 1'b1;
					end else begin
						body_d  = len_v;
						fidx_d  = '0;
						phase_d = PH_TAG;
					end
				end
				PH_TAG: begin
					body_d = body_dec;
					if (in_byte > {6'd0, TAG_MAX}) begin
						err_hit = 1'b1;
					end else begin
						tag_d   = in_byte[1:0];
						phase_d = PH_FHI;
					end
				end
				PH_FHI: begin
					body_d = body_dec;
					if (in_byte[7]) begin
						err_hit = 1'b1;
					end else begin
						high_d  = in_byte[6:0];
						phase_d = PH_FLO;
					end
				end
				PH_FLO: begin
					body_d = body_dec;
					len_v  = base127(high_q, in_byte[6:0]);
					need_v = len_v + tail_v;
					if (in_byte[7] || need_v > body_dec) begin
						err_hit = 1'b1;
					end else begin
						frem_d = len_v;
						if (len_v == '0) close_f = 1'b1;
						else phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					body_d         = body_dec;
					frem_d         = frem_dec;
					has_res        = 1'b1;
					res.data_valid = 1'b1;
					res.field_tag  = tag_q;
					res.data_byte  = in_byte;
					if (frem_dec == '0) begin
						res.field_last = 1'b1;
						close_f        = 1'b1;
					end
				end
				PH_SKIP: begin
					body_d = body_dec;
					if (body_dec == '0) begin
						phase_d        = PH_VER0;
						res.frame_done = 1'b1;
						has_res        = 1'b1;
					end
				end
				default: phase_d = PH_VER0;
			endcase

			// close the field: next tag, skip the surplus, or end the frame
			if (close_f) begin
				fidx_d = fidx_inc;
				if (fidx_inc != FIELD_COUNT) begin
					phase_d = PH_TAG;
				end else if (body_d != '0) begin
					phase_d = PH_SKIP;
				end else begin
					phase_d        = PH_VER0;
					res.frame_done = 1'b1;
					has_res        = 1'b1;
				end
			end

			// back to the start of a frame: clear the per-frame state
			if (phase_d == PH_VER0) begin
				hdr_ok_d = 1'b1;
				high_d   = '0;
				body_d   = '0;
				fidx_d   = '0;
				tag_d    = '0;
				frem_d   = '0;
			end

			if (err_hit) begin
				err_d           = 1'b1;
				res             = '0;
				res.frame_error = 1'b1;
				has_res         = 1'b1;
			end
		end
	end

	assign push     = accept && has_res;
	assign push_res = res;

	a_err_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_res.frame_error |=> err_q)
		else $error("error flag not set after error beat");
	a_quiet_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !push)
		else $error("result pushed after a sticky error");

endmodule
`default_nettype wire

@@ rtl/core/mfd_queue.sv @@
// Short result queue between the parser and the output stage.
`default_nettype none
module mfd_queue import mfd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_res,
	input  wire logic    pop,
	output logic         full,
	output logic         not_empty,
	output result_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	result_t          slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");

endmodule
`default_nettype wire

@@ rtl/core/mfd_back.sv @@
// Output stage: holds one result beat until the consumer takes it.
`default_nettype none
module mfd_back import mfd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_not_empty,
	input  wire result_t q_head,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	// refill when empty or when the held beat leaves this cycle
	assign pop       = q_not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= q_head;
	end

endmodule
`default_nettype wire

@@ rtl/core/message_frame_deframer_top.sv @@
// Top level of the message frame deframer.
// Takes one stream byte per cycle while in_stall is low and emits zero or one result
// beat per byte: a field payload byte with its tag and last mark, a frame-done mark, or
// a single frame error after which all bytes are dropped until reset. A byte enters in
// the cycle it is offered with in_stall low; its result is registered in the queue and
// then in the output register. in_stall rises only while the QUEUE_DEPTH-entry result
// queue is full, so with no output back-pressure the block sustains one byte every cycle.
`default_nettype none
module message_frame_deframer_top import mfd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            data_valid,
	output logic [1:0]      field_tag,
	output logic [7:0]      data_byte,
	output logic            field_last,
	output logic            frame_done,
	output logic            frame_error
);

	logic    accept, push, pop, q_full, q_not_empty;
	result_t push_res, q_head, out_res;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	mfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.push     (push),
		.push_res (push_res)
	);

	mfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_res     (out_res)
	);

	assign data_valid  = out_res.data_valid;
	assign field_tag   = out_res.field_tag;
	assign data_byte   = out_res.data_byte;
	assign field_last  = out_res.field_last;
	assign frame_done  = out_res.frame_done;
	assign frame_error = out_res.frame_error;

endmodule
`default_nettype wire
